// ===== design/block_cache_lru_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Block cache LRU controller: assertion macros
// Shared property shapes for the checks in the controller RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CACHE_LRU_CONTROLLER_DEFINES_SVH
`define BLOCK_CACHE_LRU_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/blc_pkg.sv =====
// ----------------------------------------------------------------------------
// Block cache LRU controller package
// Sizes, codes, request and result types and the cell entry shared by the
// cell chain and the controller.
// ----------------------------------------------------------------------------
package blc_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = 6;
    localparam int FILE_BITS  = 8;
    localparam int BLOCK_BITS = 32;
    localparam int CFG_W      = 7;

    typedef logic [SLOTS-1:0] vec_t;

    typedef enum logic [1:0] {
        LST_FREE = 2'd0,
        LST_USE  = 2'd1,
        LST_REL  = 2'd2,
        LST_NONE = 2'd3
    } lst_e;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_PUT     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_FLUSH   = 2'd3
    } op_e;

    typedef enum logic [2:0] {
        ACT_HIT      = 3'd0,
        ACT_FILL     = 3'd1,
        ACT_WB       = 3'd2,
        ACT_PUT      = 3'd3,
        ACT_DONE     = 3'd4,
        ACT_NOTFOUND = 3'd5,
        ACT_NOSLOT   = 3'd6
    } act_e;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [FILE_BITS-1:0]  file_id;
        logic [BLOCK_BITS-1:0] block_number;
        logic                  changed;
    } req_t;

    typedef struct packed {
        logic [2:0]            action;
        logic [SLOT_W-1:0]     slot;
        logic [FILE_BITS-1:0]  wb_file;
        logic [BLOCK_BITS-1:0] wb_block;
        logic                  last;
    } rsp_t;

    // One position of the global recency order. The flag marks entries that
    // are on their way to the tail of the chain.
    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        lst_e                  lst;
        logic                  dirty;
        logic [FILE_BITS-1:0]  file;
        logic [BLOCK_BITS-1:0] blk;
        logic                  flag;
    } entry_t;

    typedef struct packed {
        logic load_init;
        logic swap_l;
        logic swap_r;
        logic upd;
        logic clr_dirty;
        logic fmark;
        logic clr_flag;
    } cell_ctl_t;

    // Lowest set bit of a vector, as a one-hot vector.
    function automatic vec_t first_one(vec_t v);
        return v & (~v + vec_t'(1));
    endfunction

endpackage

// ===== design/block_cache_lru_controller.sv =====
// ----------------------------------------------------------------------------
// Block cache LRU controller
// Tag and list manager of a write-back disk block cache, built as a chain of
// cells that holds all slots in one global recency order.
// ----------------------------------------------------------------------------
// Results: the first result of a request is registered out of ST_DEC (out of
// ST_FWB for a flush); a reuse of a dirty slot puts a write-back result first,
// and a flush gives one result per cycle for each dirty slot it writes back.
// Busy then stays high while the moved entries bubble to the tail of the chain,
// one position per cycle; a put hit or a miss with no slot needs no bubbling.
// Reset: the chain loads the reset lists at once; results cannot be stalled.
// ----------------------------------------------------------------------------
`include "block_cache_lru_controller_defines.svh"

module block_cache_lru_controller
    import blc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             rsp_valid,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    // The three lists share one ordered chain. The order of a list is the
    // order of its members along the chain, so appending to any list is the
    // same as moving the entry to the tail of the chain. Moves are done by
    // flagging the entries and running an odd-even transposition pass that
    // swaps a flagged cell with an unflagged right neighbor; that pass is
    // stable, so several flagged entries keep their relative order.

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DEC   = 6'b000010,
        ST_FILL  = 6'b000100,
        ST_FWB   = 6'b001000,
        ST_FMARK = 6'b010000,
        ST_SORT  = 6'b100000
    } state_e;

    state_e state_reg, state_next;
    req_t   req_reg;
    logic [CFG_W-1:0]  act_reg;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic   any_reg, any_next;
    logic   phase_reg, phase_next;
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   rsp_reg, rsp_next;

    entry_t    q        [SLOTS];
    entry_t    init_ent [SLOTS];
    entry_t    rst_ent  [SLOTS];
    cell_ctl_t ctl      [SLOTS];
    entry_t    upd_ent;
    entry_t    rd;

    vec_t free_v, use_v, rel_v, match_v, fmatch_v, dirty_v, flag_v;
    vec_t hit_rel, hit_use, take_v, cand_v, dv, sel_v;
    logic [SLOTS-2:0] sw;
    logic [CFG_W-1:0] n_eff;
    logic unsorted;
    op_e  op;

    assign op = op_e'(req_reg.opcode);

    // Number of slots placed on the free list by a rebuild, clamped to 1..SLOTS.
    always_comb
    begin
        n_eff = act_reg;
        if (act_reg == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else if (act_reg > CFG_W'(SLOTS))
        begin
            n_eff = CFG_W'(SLOTS);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            entry_t left_in, right_in;

            always_comb
            begin
                rst_ent[gi]       = '0;
                rst_ent[gi].slot  = SLOT_W'(gi);
                rst_ent[gi].lst   = LST_FREE;
                init_ent[gi]      = '0;
                init_ent[gi].slot = SLOT_W'(gi);
                init_ent[gi].lst  = (CFG_W'(gi) < n_eff) ? LST_FREE : LST_NONE;
            end

            if (gi == 0)
            begin : g_first
                assign left_in = '0;
            end
            else
            begin : g_mid_l
                assign left_in = q[gi-1];
            end

            if (gi == SLOTS - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = q[gi+1];
            end

            blc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl[gi]),
                .rst_ent  (rst_ent[gi]),
                .init_ent (init_ent[gi]),
                .left     (left_in),
                .right    (right_in),
                .upd_ent  (upd_ent),
                .q        (q[gi])
            );
        end
    endgenerate

    // Per-cell status, compared in every cell in parallel.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            free_v[i]   = (q[i].lst == LST_FREE);
            use_v[i]    = (q[i].lst == LST_USE);
            rel_v[i]    = (q[i].lst == LST_REL);
            fmatch_v[i] = (q[i].file == req_reg.file_id);
            match_v[i]  = fmatch_v[i] && (q[i].blk == req_reg.block_number);
            dirty_v[i]  = q[i].dirty;
            flag_v[i]   = q[i].flag;
        end
        hit_rel  = rel_v & match_v;
        hit_use  = use_v & match_v;
        take_v   = (|free_v) ? first_one(free_v) : first_one(rel_v);
        cand_v   = rel_v & ((req_reg.file_id == '0) ? '1 : fmatch_v);
        dv       = cand_v & dirty_v;
        unsorted = |(flag_v[SLOTS-2:0] & ~flag_v[SLOTS-1:1]);
        for (int i = 0; i < SLOTS - 1; i++)
        begin
            sw[i] = ((i % 2) == int'(phase_reg)) && flag_v[i] && !flag_v[i+1];
        end
    end

    // The cell that this cycle's decision reads and rewrites.
    always_comb
    begin
        sel_v = '0;
        case (state_reg)
            ST_DEC:
            begin
                case (op)
                    OP_GET, OP_PUT: sel_v = (|hit_rel) ? first_one(hit_rel) : take_v;
                    OP_RELEASE:     sel_v = first_one(hit_use);
                    default:        sel_v = '0;
                endcase
            end
            ST_FWB:  sel_v = first_one(dv);
            default: sel_v = '0;
        endcase
    end

    always_comb
    begin
        rd = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rd = rd | (sel_v[i] ? q[i] : entry_t'('0));
        end
    end

    // Sequencer: decides the outcome, issues results and drives the cells.
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        any_next       = any_reg;
        phase_next     = phase_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        rsp_next.wb_file  = req_reg.file_id;
        rsp_next.wb_block = req_reg.block_number;
        rsp_next.last     = 1'b1;
        upd_ent        = rd;
        for (int i = 0; i < SLOTS; i++)
        begin
            ctl[i] = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DEC;
                end
            end

            ST_DEC:
            begin
                rsp_valid_next = 1'b1;
                any_next       = 1'b0;
                rsp_next.slot  = rd.slot;
                case (op)
                    OP_GET, OP_PUT:
                    begin
                        if (|hit_rel)
                        begin
                            if (op == OP_GET)
                            begin
                                upd_ent.lst    = LST_USE;
                                upd_ent.flag   = 1'b1;
                                rsp_next.action = ACT_HIT;
                                state_next     = ST_SORT;
                            end
                            else
                            begin
                                // A put hit stays in place on the released list.
                                upd_ent.dirty   = 1'b1;
                                rsp_next.action = ACT_PUT;
                                state_next      = ST_IDLE;
                            end
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                ctl[i].upd = sel_v[i];
                            end
                        end
                        else if (|take_v)
                        begin
                            upd_ent.lst   = (op == OP_GET) ? LST_USE : LST_REL;
                            upd_ent.dirty = (op == OP_PUT);
                            upd_ent.file  = req_reg.file_id;
                            upd_ent.blk   = req_reg.block_number;
                            upd_ent.flag  = 1'b1;
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                ctl[i].upd = sel_v[i];
                            end
                            if (rd.dirty)
                            begin
                                // Reused dirty slot: its old tag goes out first.
                                rsp_next.action   = ACT_WB;
                                rsp_next.wb_file  = rd.file;
                                rsp_next.wb_block = rd.blk;
                                rsp_next.last     = 1'b0;
                                slot_next         = rd.slot;
                                state_next        = ST_FILL;
                            end
                            else
                            begin
                                rsp_next.action = (op == OP_GET) ? ACT_FILL : ACT_PUT;
                                state_next      = ST_SORT;
                            end
                        end
                        else
                        begin
                            rsp_next.action = ACT_NOSLOT;
                            rsp_next.slot   = '0;
                            state_next      = ST_IDLE;
                        end
                    end

                    OP_RELEASE:
                    begin
                        if (|hit_use)
                        begin
                            upd_ent.dirty   = rd.dirty | req_reg.changed;
                            upd_ent.lst     = LST_REL;
                            upd_ent.flag    = 1'b1;
                            rsp_next.action = ACT_DONE;
                            state_next      = ST_SORT;
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                ctl[i].upd = sel_v[i];
                            end
                        end
                        else
                        begin
                            rsp_next.action = ACT_NOTFOUND;
                            rsp_next.slot   = '0;
                            state_next      = ST_IDLE;
                        end
                    end

                    default:
                    begin
                        rsp_valid_next = 1'b0;
                        state_next     = ST_FWB;
                    end
                endcase
            end

            ST_FILL:
            begin
                rsp_valid_next  = 1'b1;
                rsp_next.action = (op == OP_GET) ? ACT_FILL : ACT_PUT;
                rsp_next.slot   = slot_reg;
                state_next      = ST_SORT;
            end

            ST_FWB:
            begin
                // Write back the dirty matching released slots in release order.
                if (|dv)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.action   = ACT_WB;
                    rsp_next.slot     = rd.slot;
                    rsp_next.wb_file  = rd.file;
                    rsp_next.wb_block = rd.blk;
                    rsp_next.last     = ~|(dv & ~sel_v);
                    any_next          = 1'b1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        ctl[i].clr_dirty = sel_v[i];
                    end
                end
                else
                begin
                    if (!any_reg)
                    begin
                        rsp_valid_next    = 1'b1;
                        rsp_next.action   = ACT_DONE;
                        rsp_next.slot     = '0;
                        rsp_next.wb_block = '0;
                    end
                    state_next = ST_FMARK;
                end
            end

            ST_FMARK:
            begin
                if (req_reg.file_id == '0)
                begin
                    // Full flush: every list is rebuilt from the register, with the first n_eff slots free.
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        ctl[i].load_init = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        ctl[i].fmark = cand_v[i];
                    end
                    state_next = ST_SORT;
                end
            end

            ST_SORT:
            begin
                if (unsorted)
                begin
                    for (int i = 0; i < SLOTS - 1; i++)
                    begin
                        ctl[i].swap_r   = sw[i];
                        ctl[i+1].swap_l = sw[i];
                    end
                    phase_next = ~phase_reg;
                end
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        ctl[i].clr_flag = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= CFG_W'(SLOTS);
            any_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            any_reg       <= any_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                act_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        slot_reg <= slot_next;
        if (start && (state_reg == ST_IDLE))
        begin
            req_reg <= req;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BLC_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
    `BLC_ASSERT_IMP(a_rsp_from_work, rsp_valid, $past(state_reg) != ST_IDLE, "result while idle")
    `BLC_ASSERT_IMP(a_idle_no_flags, state_reg == ST_IDLE, flag_v == '0, "flag left in chain")

endmodule

// ===== design/blc_cell.sv =====
// ----------------------------------------------------------------------------
// Block cache LRU cell
// One position of the recency chain: holds one slot entry and exchanges it
// with a neighbor when the controller orders a swap.
// ----------------------------------------------------------------------------
module blc_cell
    import blc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    rst_ent,
    input  entry_t    init_ent,
    input  entry_t    left,
    input  entry_t    right,
    input  entry_t    upd_ent,
    output entry_t    q
);

    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.load_init)
        begin
            ent_next = init_ent;
        end
        else if (ctl.swap_l)
        begin
            ent_next = left;
        end
        else if (ctl.swap_r)
        begin
            ent_next = right;
        end
        else if (ctl.upd)
        begin
            ent_next = upd_ent;
        end
        else
        begin
            if (ctl.clr_dirty)
            begin
                ent_next.dirty = 1'b0;
            end
            if (ctl.fmark)
            begin
                ent_next.lst   = LST_FREE;
                ent_next.dirty = 1'b0;
                ent_next.file  = '0;
                ent_next.blk   = '0;
                ent_next.flag  = 1'b1;
            end
            if (ctl.clr_flag)
            begin
                ent_next.flag = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= rst_ent;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    assign q = ent_reg;

endmodule

// ===== tb/block_cache_lru_checker.sv =====
// ----------------------------------------------------------------------------
// Block cache LRU controller checker
// Watches the request, result and register ports, keeps its own copy of the
// slot lists and tags, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module block_cache_lru_checker
    import blc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  req_t             req,
    input  logic             rsp_valid,
    input  rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NIL = SLOTS;

    lst_e                  where_is[SLOTS];
    bit                    dirty[SLOTS];
    logic [FILE_BITS-1:0]  tag_file[SLOTS];
    logic [BLOCK_BITS-1:0] tag_blk[SLOTS];
    int                    nxt[SLOTS];
    int                    prv[SLOTS];
    int                    heads[3];
    int                    tails[3];
    logic [CFG_W-1:0]      active_cfg;
    rsp_t                  expected_rsps[$];

    assign pending = expected_rsps.size();

    function automatic void rebuild_lists();
        int n;
        n = active_cfg;
        if (n < 1) n = 1;
        if (n > SLOTS) n = SLOTS;
        for (int i = 0; i < SLOTS; i++)
        begin
            dirty[i] = 0;
            tag_file[i] = '0;
            tag_blk[i] = '0;
            where_is[i] = (i < n) ? LST_FREE : LST_NONE;
            nxt[i] = (i < n && i + 1 < n) ? i + 1 : NIL;
            prv[i] = (i < n && i > 0) ? i - 1 : NIL;
        end
        heads[LST_FREE] = 0;
        tails[LST_FREE] = n - 1;
        heads[LST_USE] = NIL;
        tails[LST_USE] = NIL;
        heads[LST_REL] = NIL;
        tails[LST_REL] = NIL;
    endfunction

    function automatic void unlink(lst_e l, int s);
        int nx;
        int pv;
        nx = nxt[s];
        pv = prv[s];
        if (heads[l] == s) heads[l] = nx;
        else if (pv < SLOTS) nxt[pv] = nx;
        if (tails[l] == s) tails[l] = pv;
        else if (nx < SLOTS) prv[nx] = pv;
        nxt[s] = NIL;
        prv[s] = NIL;
        where_is[s] = LST_NONE;
    endfunction

    function automatic void append(lst_e l, int s);
        int t;
        t = tails[l];
        if (heads[l] >= SLOTS) heads[l] = s;
        if (t < SLOTS) nxt[t] = s;
        prv[s] = (t < SLOTS) ? t : NIL;
        tails[l] = s;
        nxt[s] = NIL;
        where_is[s] = l;
    endfunction

    function automatic void push_rsp(act_e a, int s, logic [FILE_BITS-1:0] f,
                                     logic [BLOCK_BITS-1:0] b, bit last);
        rsp_t r;
        r.action = a;
        r.slot = SLOT_W'(s);
        r.wb_file = f;
        r.wb_block = b;
        r.last = last;
        expected_rsps.push_back(r);
    endfunction

    function automatic int find_tag(lst_e l, logic [FILE_BITS-1:0] f,
                                    logic [BLOCK_BITS-1:0] b);
        int s;
        int steps;
        s = heads[l];
        steps = 0;
        while (s < SLOTS && steps < SLOTS)
        begin
            if (tag_blk[s] == b && tag_file[s] == f) return s;
            s = nxt[s];
            steps++;
        end
        return NIL;
    endfunction

    // A miss takes the free head, else the oldest released slot, which is
    // written back first when it is dirty.
    function automatic int claim_slot(lst_e l, logic [FILE_BITS-1:0] f,
                                      logic [BLOCK_BITS-1:0] b);
        int s;
        s = heads[LST_FREE];
        if (s < SLOTS)
            unlink(LST_FREE, s);
        else
        begin
            s = heads[LST_REL];
            if (s >= SLOTS) return NIL;
            if (dirty[s]) push_rsp(ACT_WB, s, tag_file[s], tag_blk[s], 0);
            unlink(LST_REL, s);
        end
        append(l, s);
        tag_file[s] = f;
        tag_blk[s] = b;
        return s;
    endfunction

    function automatic void predict_request(req_t r);
        int s;
        int nx;
        int steps;
        int first;
        rsp_t tmp;
        case (op_e'(r.opcode))
            OP_GET:
            begin
                s = find_tag(LST_REL, r.file_id, r.block_number);
                if (s < SLOTS)
                begin
                    unlink(LST_REL, s);
                    append(LST_USE, s);
                    push_rsp(ACT_HIT, s, r.file_id, r.block_number, 1);
                end
                else
                begin
                    s = claim_slot(LST_USE, r.file_id, r.block_number);
                    if (s < SLOTS)
                    begin
                        dirty[s] = 0;
                        push_rsp(ACT_FILL, s, r.file_id, r.block_number, 1);
                    end
                    else
                        push_rsp(ACT_NOSLOT, 0, r.file_id, r.block_number, 1);
                end
            end
            OP_PUT:
            begin
                s = find_tag(LST_REL, r.file_id, r.block_number);
                if (s >= SLOTS) s = claim_slot(LST_REL, r.file_id, r.block_number);
                if (s < SLOTS)
                begin
                    dirty[s] = 1;
                    push_rsp(ACT_PUT, s, r.file_id, r.block_number, 1);
                end
                else
                    push_rsp(ACT_NOSLOT, 0, r.file_id, r.block_number, 1);
            end
            OP_RELEASE:
            begin
                s = find_tag(LST_USE, r.file_id, r.block_number);
                if (s < SLOTS)
                begin
                    dirty[s] = dirty[s] | r.changed;
                    unlink(LST_USE, s);
                    append(LST_REL, s);
                    push_rsp(ACT_DONE, s, r.file_id, r.block_number, 1);
                end
                else
                    push_rsp(ACT_NOTFOUND, 0, r.file_id, r.block_number, 1);
            end
            default:
            begin
                first = expected_rsps.size();
                s = heads[LST_REL];
                steps = 0;
                while (s < SLOTS && steps < SLOTS)
                begin
                    nx = nxt[s];
                    if (r.file_id == 0 || tag_file[s] == r.file_id)
                    begin
                        if (dirty[s]) push_rsp(ACT_WB, s, tag_file[s], tag_blk[s], 0);
                        dirty[s] = 0;
                        tag_file[s] = '0;
                        tag_blk[s] = '0;
                        unlink(LST_REL, s);
                        append(LST_FREE, s);
                    end
                    s = nx;
                    steps++;
                end
                if (r.file_id == 0) rebuild_lists();
                if (expected_rsps.size() > first)
                begin
                    tmp = expected_rsps.pop_back();
                    tmp.last = 1;
                    expected_rsps.push_back(tmp);
                end
                else
                    push_rsp(ACT_DONE, 0, r.file_id, '0, 1);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            active_cfg = 7'd64;
            rebuild_lists();
            expected_rsps.delete();
            results_seen = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we) active_cfg = cfg_data;
            if (start && !busy) predict_request(req);
            if (rsp_valid)
            begin
                results_seen++;
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected result", rsp, 0);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.action !== want.action)
                        report_mismatch("action", rsp.action, want.action);
                    if (rsp.slot !== want.slot)
                        report_mismatch("slot", rsp.slot, want.slot);
                    if (rsp.wb_file !== want.wb_file)
                        report_mismatch("wb_file", rsp.wb_file, want.wb_file);
                    if (rsp.wb_block !== want.wb_block)
                        report_mismatch("wb_block", rsp.wb_block, want.wb_block);
                    if (rsp.last !== want.last)
                        report_mismatch("last", rsp.last, want.last);
                end
            end
        end
    end

endmodule

// ===== tb/tb_block_cache_lru_controller.sv =====
// ----------------------------------------------------------------------------
// Block cache LRU controller testbench
// Drives directed and random get, put, release and flush requests through
// several slot counts; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_block_cache_lru_controller;
    import blc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no accepted request and no result before the run is
    // declared hung. This leaves a wide margin over the longest flush and
    // over the quiet time before a register write.
    localparam int HANG_LIMIT = 5000;
    // Quiet time once nothing is expected: a flush with no write-back can
    // still be bubbling entries through the chain.
    localparam int DRAIN_CYCLES = 150;
    localparam int PER_PHASE = 26;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             rsp_valid;
    rsp_t             rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               results_seen;
    int               requests_sent;
    int               quiet_cycles;

    // Tags recently fetched with get, so that most releases hit a slot that
    // is really in use.
    req_t held_tags[$];

    block_cache_lru_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    block_cache_lru_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hang detection: any accepted request or result resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || rsp_valid)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no progress for %0d cycles", HANG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic req_t make_req(op_e op, int f, longint b, bit chg);
        req_t r;
        r.opcode = op;
        r.file_id = f[FILE_BITS-1:0];
        r.block_number = b[BLOCK_BITS-1:0];
        r.changed = chg;
        return r;
    endfunction

    // Holds start high with the request until the block takes it. Busy is
    // read right after the edge, so it is the value the block itself saw.
    task automatic send_request(req_t r);
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        requests_sent++;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Register writes happen only with the block quiet: every expected
    // result has come, and a flush that gave no write-back has had time to
    // finish its bubbling.
    task automatic write_active_slots(logic [CFG_W-1:0] v);
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random requests mostly use a few files and low block numbers so that
    // hits, reuse of dirty slots and flush matches are frequent; the rest
    // uses the full field ranges so that every bit toggles.
    function automatic req_t random_req();
        req_t   r;
        int     pick;
        int     f;
        longint b;
        pick = $urandom_range(99);
        f = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 3);
        b = ($urandom_range(6) == 0) ? longint'($urandom) : $urandom_range(1, 6);
        if (pick < 40)
        begin
            r = make_req(OP_GET, f, b, 1'($urandom_range(1)));
            held_tags.push_back(r);
            if (held_tags.size() > 16) void'(held_tags.pop_front());
        end
        else if (pick < 60)
            r = make_req(OP_PUT, f, b, 1'($urandom_range(1)));
        else if (pick < 90)
        begin
            if (held_tags.size() > 0 && $urandom_range(3) != 0)
            begin
                r = held_tags[$urandom_range(held_tags.size() - 1)];
                r.opcode = OP_RELEASE;
                r.changed = 1'($urandom_range(1));
            end
            else
                r = make_req(OP_RELEASE, f, b, 1'($urandom_range(1)));
        end
        else
        begin
            // A full flush empties the in-use and released lists, so it is kept rare.
            if ($urandom_range(3) == 0) f = 0;
            r = make_req(OP_FLUSH, f, b, 1'($urandom_range(1)));
        end
        return r;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] phase_cfg[6];
        int               item_no;
        phase_cfg = '{7'd0, 7'd127, 7'd64, 7'd1, 7'd5, 7'd2};
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        requests_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with three slots, so that running out of slots is
        // easy to reach. The full flush makes the new count take effect.
        write_active_slots(7'd3);
        send_request(make_req(OP_FLUSH, 0, 0, 0));
        send_request(make_req(OP_GET, 1, 1, 0));
        send_request(make_req(OP_GET, 255, 64'hFFFF_FFFF, 1));
        send_request(make_req(OP_GET, 0, 0, 0));
        // Free and released lists are both empty now.
        send_request(make_req(OP_GET, 1, 2, 0));
        send_request(make_req(OP_PUT, 2, 2, 0));
        send_request(make_req(OP_RELEASE, 1, 1, 1));
        send_request(make_req(OP_RELEASE, 9, 9, 0));
        send_request(make_req(OP_RELEASE, 255, 64'hFFFF_FFFF, 0));
        // Put miss that reuses the dirty released slot: write-back first.
        send_request(make_req(OP_PUT, 7, 5, 1));
        send_request(make_req(OP_PUT, 7, 5, 0));
        send_request(make_req(OP_GET, 7, 5, 0));
        send_request(make_req(OP_RELEASE, 7, 5, 0));
        send_request(make_req(OP_FLUSH, 7, 0, 0));
        send_request(make_req(OP_FLUSH, 3, 64'hFFFF_FFFF, 1));
        send_request(make_req(OP_RELEASE, 0, 0, 1));
        send_request(make_req(OP_PUT, 128, 64'h8000_0000, 0));
        // Full flush that writes back the dirty released slots.
        send_request(make_req(OP_FLUSH, 0, 0, 0));

        item_no = 0;
        foreach (phase_cfg[p])
        begin
            write_active_slots(phase_cfg[p]);
            send_request(make_req(OP_FLUSH, 0, 0, 0));
            for (int i = 0; i < PER_PHASE; i++)
            begin
                // Random gaps, except in one long stretch in the middle.
                if ((item_no < 60 || item_no > 110) && $urandom_range(99) < 19)
                    idle_cycles($urandom_range(1, 4));
                send_request(random_req());
                item_no++;
            end
        end

        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d results over seven register settings,",
                 requests_sent, results_seen);
        $display("from one slot to the full 64, with flushes of one file and of all.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== block_cache_lru_controller.f =====
+incdir+design
design/blc_pkg.sv
design/blc_cell.sv
design/block_cache_lru_controller.sv
tb/block_cache_lru_checker.sv
tb/tb_block_cache_lru_controller.sv
